FILE: design/thumb_instruction_decoder_assert.svh
// Assertion macros used by the decoder port checker.
`ifndef THUMB_INSTRUCTION_DECODER_ASSERT_SVH
`define THUMB_INSTRUCTION_DECODER_ASSERT_SVH

// Implication checked on every clock edge out of reset.
`define TID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked out of reset.
`define TID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tid_pkg.sv
// Package with kind codes, register codes and the decoded result type.
package tid_pkg;

  typedef enum logic [6:0] {
    K_NOP = 7'd0, K_MOV_LSL = 7'd1, K_LSL = 7'd2, K_LSR = 7'd3, K_ASR = 7'd4,
    K_ADD = 7'd5, K_SUB = 7'd6, K_ADD3I = 7'd7, K_SUB3I = 7'd8, K_MOV = 7'd9,
    K_CMP = 7'd10, K_ADD8I = 7'd11, K_SUB8I = 7'd12, K_AND_R = 7'd13,
    K_TST_R = 7'd21, K_RSB_I = 7'd22, K_CMP_R = 7'd23, K_CMN_R = 7'd24,
    K_MVN_R = 7'd28, K_BX = 7'd29, K_BLX = 7'd30, K_LDR = 7'd31, K_STR = 7'd32,
    K_STRH = 7'd33, K_STRB = 7'd34, K_LDRSB = 7'd35, K_LDRH = 7'd36,
    K_LDRB = 7'd37, K_LDRSH = 7'd38, K_ADR = 7'd39, K_CBZ = 7'd40,
    K_SXTH = 7'd41, K_PUSH = 7'd45, K_SETEND = 7'd46, K_CPS = 7'd47,
    K_CBNZ = 7'd48, K_REV = 7'd49, K_REV16 = 7'd50, K_REVSH = 7'd51,
    K_POP = 7'd52, K_BKPT = 7'd53, K_IT = 7'd54, K_STM = 7'd55, K_LDM = 7'd56,
    K_UDF = 7'd57, K_SVC = 7'd58, K_B = 7'd59, K_DSB = 7'd60, K_MRS = 7'd63,
    K_BL = 7'd64
  } kind_t;

  localparam logic [4:0] R_SP      = 5'd13;
  localparam logic [4:0] R_PC      = 5'd15;
  localparam logic [4:0] R_PRIMASK = 5'd16;
  localparam logic [4:0] R_NONE    = 5'd17;
  localparam logic [3:0] COND_AL   = 4'd14;

  typedef struct packed {
    logic [6:0]  kind;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic        iv;
    logic [31:0] imm;
    logic [3:0]  cond;
    logic [3:0]  opt;
    logic        wide;
  } dec_t;

endpackage

FILE: design/tid_decode.sv
// Combinational decode of one 16-bit or 32-bit Thumb instruction.
module tid_decode
  import tid_pkg::*;
(
  input  logic        wide,
  input  logic [31:0] bits_i,
  input  logic [31:0] addr,
  output dec_t        dec
);

  logic [15:0] b;
  logic [5:0]  op;
  logic [4:0]  lo, mid, hi, r8, imm5, full, m4;
  logic [4:0]  o5;
  logic [3:0]  o4, opa;
  logic [6:0]  mop;
  logic [31:0] cboff, pc4;
  logic [31:0] w;
  logic        s, j1, j2, i1, i2;
  logic [24:0] off25;
  logic [20:0] off21;

  always_comb begin
    b     = bits_i[15:0];
    w     = bits_i;
    op    = b[15:10];
    lo    = {2'b0, b[2:0]};
    mid   = {2'b0, b[5:3]};
    hi    = {2'b0, b[8:6]};
    r8    = {2'b0, b[10:8]};
    imm5  = b[10:6];
    full  = {1'b0, b[7], b[2:0]};
    m4    = {1'b0, b[6:3]};
    o5    = b[13:9];
    o4    = b[9:6];
    opa   = b[15:12];
    mop   = b[11:5];
    cboff = {25'd0, b[9], b[7:3], 1'b0};
    pc4   = addr + 32'd4;
    s     = w[26];
    j1    = w[13];
    j2    = w[11];
    i1    = ~(j1 ^ s);
    i2    = ~(j2 ^ s);
    off25 = {s, i1, i2, w[25:16], w[10:0], 1'b0};
    off21 = {s, j2, j1, w[21:16], w[10:0], 1'b0};

    dec      = '0;
    dec.kind = K_NOP;
    dec.rd   = R_NONE;
    dec.rn   = R_NONE;
    dec.rm   = R_NONE;
    dec.cond = COND_AL;
    dec.wide = wide;

    if (wide) begin
      if (w[31:27] == 5'b11110) begin
        if (w[31:4] == 28'hf3bf8f4 || w[31:4] == 28'hf3bf8f5 ||
            w[31:4] == 28'hf3bf8f6) begin
          dec.kind = K_DSB + {3'd0, w[7:4]} - 7'd4;
          dec.opt  = w[3:0];
        end else if (w[31:21] == 11'b11110011111) begin
          dec.kind = K_MRS;
          dec.rd   = {1'b0, w[11:8]};
          dec.rn   = R_PRIMASK;
        end else if (w[12]) begin
          dec.kind = w[14] ? K_BL : K_B;
          dec.iv   = 1'b1;
          dec.imm  = pc4 + {{7{off25[24]}}, off25};
        end else if (!w[14]) begin
          dec.kind = K_B;
          dec.cond = w[25:22];
          dec.iv   = 1'b1;
          dec.imm  = pc4 + {{11{off21[20]}}, off21};
        end
      end
    end else begin
      if (op[5:4] == 2'b00) begin
        if (o5[4:2] <= 3'd2) begin
          dec.rd = lo;
          dec.rm = mid;
          if (o5[4:2] == 3'd0) begin
            if (imm5 == 5'd0) begin
              dec.kind = K_MOV_LSL;
            end else begin
              dec.kind = K_LSL;
              dec.iv   = 1'b1;
              dec.imm  = {27'd0, imm5};
            end
          end else begin
            dec.kind = (o5[4:2] == 3'd1) ? K_LSR : K_ASR;
            dec.iv   = 1'b1;
            dec.imm  = (imm5 != 5'd0) ? {27'd0, imm5} : 32'd32;
          end
        end else if (o5 == 5'h0c || o5 == 5'h0d) begin
          dec.kind = (o5 == 5'h0c) ? K_ADD : K_SUB;
          dec.rd = lo; dec.rn = mid; dec.rm = hi;
        end else if (o5 == 5'h0e || o5 == 5'h0f) begin
          dec.kind = (o5 == 5'h0e) ? K_ADD3I : K_SUB3I;
          dec.rd = lo; dec.rn = mid;
          dec.iv = 1'b1; dec.imm = {27'd0, hi};
        end else begin
          dec.kind = K_MOV + {5'd0, o5[3:2]};
          dec.iv   = 1'b1;
          dec.imm  = {24'd0, b[7:0]};
          if (o5[4:2] != 3'd4) dec.rn = r8;
          if (o5[4:2] != 3'd5) dec.rd = r8;
        end
      end else if (op == 6'h10) begin
        dec.kind = K_AND_R + {3'd0, o4};
        if (o4 == 4'd8 || o4 == 4'd10 || o4 == 4'd11) begin
          dec.rn = lo; dec.rm = mid;
        end else if (o4 == 4'd9 || o4 == 4'd13 || o4 == 4'd15) begin
          dec.rd = lo; dec.rn = mid;
        end else begin
          dec.rd = lo; dec.rn = lo; dec.rm = mid;
        end
      end else if (op == 6'h11) begin
        if (o4 == 4'd0) begin
          dec.kind = K_ADD; dec.rd = lo; dec.rn = lo; dec.rm = mid;
        end else if (o4 <= 4'd3) begin
          dec.kind = K_ADD; dec.rd = full; dec.rn = full; dec.rm = m4;
        end else if (o4 <= 4'd7) begin
          dec.kind = K_CMP; dec.rn = full; dec.rm = m4;
        end else if (o4 == 4'd8) begin
          dec.kind = K_MOV; dec.rd = lo; dec.rm = mid;
        end else if (o4 <= 4'd11) begin
          dec.kind = K_MOV; dec.rd = full; dec.rm = m4;
        end else if (o4 <= 4'd13) begin
          dec.kind = K_BX; dec.rm = m4;
        end else if (b[2:0] == 3'd0) begin
          dec.kind = K_BLX; dec.rm = m4;
        end
      end else if (op[5:1] == 5'h09) begin
        dec.kind = K_LDR; dec.rd = r8; dec.rn = R_PC;
        dec.iv = 1'b1; dec.imm = {22'd0, b[7:0], 2'b00};
      end else if (op[5:2] == 4'd5 || op[5:3] == 3'd3 || op[5:3] == 3'd4) begin
        if (opa == 4'd5) begin
          case (b[11:9])
            3'd0:    dec.kind = K_STR;
            3'd1:    dec.kind = K_STRH;
            3'd2:    dec.kind = K_STRB;
            3'd3:    dec.kind = K_LDRSB;
            3'd4:    dec.kind = K_LDR;
            3'd5:    dec.kind = K_LDRH;
            3'd6:    dec.kind = K_LDRB;
            default: dec.kind = K_LDRSH;
          endcase
          dec.rd = lo; dec.rn = mid; dec.rm = hi;
        end else if (opa == 4'd9) begin
          dec.kind = b[11] ? K_LDR : K_STR;
          dec.rd = r8; dec.rn = R_SP;
          dec.iv = 1'b1; dec.imm = {22'd0, b[7:0], 2'b00};
        end else begin
          dec.rd = lo; dec.rn = mid; dec.iv = 1'b1;
          if (opa == 4'd6) begin
            dec.kind = b[11] ? K_LDR : K_STR; dec.imm = {25'd0, imm5, 2'b00};
          end else if (opa == 4'd7) begin
            dec.kind = b[11] ? K_LDRB : K_STRB; dec.imm = {27'd0, imm5};
          end else begin
            dec.kind = b[11] ? K_LDRH : K_STRH; dec.imm = {26'd0, imm5, 1'b0};
          end
        end
      end else if (op[5:1] == 5'h14) begin
        dec.kind = K_ADR; dec.rd = r8; dec.rn = R_PC;
        dec.iv = 1'b1; dec.imm = {22'd0, b[7:0], 2'b00};
      end else if (op[5:1] == 5'h15) begin
        dec.kind = K_ADD; dec.rd = r8; dec.rm = R_SP;
        dec.iv = 1'b1; dec.imm = {22'd0, b[7:0], 2'b00};
      end else if (op[5:2] == 4'hb) begin
        if (mop[6:2] == 5'd0 || mop[6:2] == 5'd1) begin
          dec.kind = mop[2] ? K_SUB : K_ADD;
          dec.rd = R_SP; dec.rn = R_SP;
          dec.iv = 1'b1; dec.imm = {23'd0, b[6:0], 2'b00};
        end else if (mop[6:3] == 4'd1 || mop[6:3] == 4'd3) begin
          dec.kind = K_CBZ; dec.rn = lo; dec.iv = 1'b1; dec.imm = cboff;
        end else if (mop[6:3] == 4'd9 || mop[6:3] == 4'd11) begin
          dec.kind = K_CBNZ; dec.rn = lo; dec.iv = 1'b1; dec.imm = cboff;
        end else if (mop[6:3] == 4'd2) begin
          dec.kind = K_SXTH + {5'd0, mop[2:1]}; dec.rd = lo; dec.rm = mid;
        end else if (mop[6:4] == 3'd2) begin
          dec.kind = K_PUSH; dec.iv = 1'b1; dec.imm = {24'd0, b[7:0]};
        end else if (mop == 7'h32) begin
          dec.kind = K_SETEND; dec.iv = 1'b1; dec.imm = {31'd0, b[3]};
        end else if (mop == 7'h33) begin
          dec.kind = K_CPS; dec.iv = 1'b1; dec.imm = {27'd0, b[4:0]};
        end else if (mop[6:1] == 6'h28 || mop[6:1] == 6'h29 ||
                     mop[6:1] == 6'h2b) begin
          dec.kind = (mop[6:1] == 6'h28) ? K_REV :
                     (mop[6:1] == 6'h29) ? K_REV16 : K_REVSH;
          dec.rd = lo; dec.rm = mid;
        end else if (mop[6:4] == 3'd6) begin
          dec.kind = K_POP; dec.iv = 1'b1; dec.imm = {24'd0, b[7:0]};
        end else if (mop[6:3] == 4'd14) begin
          dec.kind = K_BKPT; dec.iv = 1'b1; dec.imm = {24'd0, b[7:0]};
        end else if (mop[6:3] == 4'd15 && b[7:4] != 4'd0) begin
          dec.kind = K_IT; dec.cond = b[7:4];
          dec.iv = 1'b1; dec.imm = {28'd0, b[3:0]};
        end
      end else if (op[5:1] == 5'h18 || op[5:1] == 5'h19) begin
        dec.kind = op[1] ? K_LDM : K_STM; dec.rn = r8;
        dec.iv = 1'b1; dec.imm = {24'd0, b[7:0]};
      end else if (op[5:2] == 4'hd) begin
        if (b[11:8] == 4'd14) begin
          dec.kind = K_UDF;
        end else if (b[11:8] == 4'd15) begin
          dec.kind = K_SVC; dec.iv = 1'b1; dec.imm = {24'd0, b[7:0]};
        end else begin
          dec.kind = K_B; dec.cond = b[11:8]; dec.iv = 1'b1;
          dec.imm  = pc4 + {{23{b[7]}}, b[7:0], 1'b0};
        end
      end else if (op[5:1] == 5'h1c) begin
        dec.kind = K_B; dec.iv = 1'b1;
        dec.imm  = pc4 + {{20{b[10]}}, b[10:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/thumb_instruction_decoder.sv
// Top level: input register, decode logic and output register with skid.
//  channel | dir | tdata fields (low bit up)                 | tuser
//  in_     | in  | action, instr_bits, instr_addr            | -
//  out_    | out | kind,dest,src1,src2,imm_valid,imm,cond,   | -
//          |     | barrier_option, is_wide                   |
// One instruction per cycle while out_tready is high.
// The input register feeds the decode logic; the decoded result is held in
// the output register, with a one-entry skid buffer taking the result
// whose way out is blocked, so in_tready depends only on registered state.
// Reset (rst_n low, synchronous) empties all stages.
module thumb_instruction_decoder
  import tid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // action[0], instr_bits[32:1], instr_addr[64:33], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // kind[6:0], dest_reg[11:7], first_src_reg[16:12],
                                  // second_src_reg[21:17], imm_valid[22],
                                  // imm_value[54:23], cond_code[58:55],
                                  // barrier_option[62:59], is_wide[63], zero
);

  logic        s1_v_r, o_v_r, k_v_r;
  logic        s1_wide_r;
  logic [31:0] s1_bits_r, s1_addr_r;
  dec_t        dec, o_r, k_r;
  logic        o_take, s1_adv;

  tid_decode u_dec (
    .wide   (s1_wide_r),
    .bits_i (s1_bits_r),
    .addr   (s1_addr_r),
    .dec    (dec)
  );

  assign o_take    = out_tready || !o_v_r;
  assign in_tready = !k_v_r;
  assign s1_adv    = s1_v_r && !k_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
      k_v_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      // output register refill: skid first, else the decode
      if (o_take) begin
        if (k_v_r) begin
          o_v_r <= 1'b1;
          k_v_r <= 1'b0;
        end else begin
          o_v_r <= s1_adv;
        end
      end else if (s1_adv) begin
        k_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_wide_r <= in_tdata[0];
      s1_bits_r <= in_tdata[32:1];
      s1_addr_r <= in_tdata[64:33];
    end
    if (o_take) begin
      o_r <= k_v_r ? k_r : dec;
    end else if (s1_adv) begin
      k_r <= dec;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {8'd0, o_r.wide, o_r.opt, o_r.cond, o_r.imm, o_r.iv,
                       o_r.rm, o_r.rn, o_r.rd, o_r.kind};

endmodule

FILE: design/tid_checker.sv
// Port-level checker for the decoder, bound to the top level.
`include "thumb_instruction_decoder_assert.svh"
module tid_port_checker
  import tid_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  `TID_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped while stalled")
  `TID_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[71:64] == 8'd0, "tdata padding not zero")
  `TID_ASSERT_IMP(a_nop_clean, clk, rst_n, out_tvalid && out_tdata[6:0] == 7'd0, out_tdata[22] == 1'b0 && out_tdata[11:7] == R_NONE, "nop with fields set")
  `TID_ASSERT_IMP(a_imm_zero, clk, rst_n, out_tvalid && !out_tdata[22], out_tdata[54:23] == 32'd0, "immediate without valid flag")
  `TID_ASSERT_NXT(a_flow, clk, rst_n, in_tvalid && in_tready && out_tready, out_tvalid || in_tready, "pipeline stalled without back pressure")

endmodule

bind thumb_instruction_decoder tid_port_checker u_tid_checker (.*);
